// ----- design/bounded_stack_engine_assert.svh -----
`ifndef BOUNDED_STACK_ENGINE_ASSERT_SVH
`define BOUNDED_STACK_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define BSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BSE_ASSERT(label, prop, msg)
`define BSE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- design/bse_pkg.sv -----
`default_nettype none

package bse_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned CountW = 5;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH   = 3'd0,
    FUNC_POP    = 3'd1,
    FUNC_PEEK   = 3'd2,
    FUNC_CLEAR  = 3'd3,
    FUNC_REMOVE = 3'd4
  } bse_func_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_REFUSED = 2'd1,
    STAT_EMPTIED = 2'd2
  } bse_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TOP,
    ST_REMOVE
  } bse_state_e;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic signed [DataW-1:0] value;
  } bse_req_t;

  typedef struct packed {
    bse_status_e             status;
    logic signed [DataW-1:0] data;
    logic [CountW-1:0]       count;
    logic                    is_empty;
    logic                    is_full;
  } bse_rsp_t;

endpackage

`default_nettype wire

// ----- design/bounded_stack_engine.sv -----
// Bounded LIFO stack of signed 32-bit words, DEPTH entries deep.
// Input channel (in_valid_i / in_ready_o / in_req_i): one request per transfer,
// func selects push, pop, peek, clear or remove-all-equal-to-value.
// Output channel (out_valid_o / out_ready_i / out_rsp_o): one response per
// request with status, popped or peeked word, count and empty/full flags.
// Push, clear and refused requests land in the output register at the
// accepting edge; pop and peek first pass through ST_TOP for the memory read.
// Remove walks the stored entries through the one read port and the one write
// port of the entry memory, and holds off the input until the walk is done.
// The single-item sequencer takes push and clear at one request per cycle while
// the receiver keeps up, but no new request before a pop or peek read is done.
// A new request is taken only while the sequencer is idle and the output
// register is empty or being drained in the same cycle; a stalled receiver
// therefore holds off the input channel.
// Reset empties the stack at once; memory contents are left as they are and
// only entries below the fill count are ever used.
`default_nettype none

`include "bounded_stack_engine_assert.svh"

module bounded_stack_engine #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire bse_pkg::bse_req_t in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output bse_pkg::bse_rsp_t      out_rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                      slot_free;
  logic                      res_valid;
  bse_pkg::bse_rsp_t         res;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [bse_pkg::DataW-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic [bse_pkg::DataW-1:0] mem_rdata;

  logic              out_valid_q, out_valid_d;
  bse_pkg::bse_rsp_t out_rsp_q;

  assign slot_free = !out_valid_q || out_ready_i;

  bse_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .slot_free_i(slot_free),
    .res_valid_o(res_valid),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  bse_ram #(
    .Width(bse_pkg::DataW),
    .Depth(DEPTH)
  ) u_entries (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `BSE_ASSERT(a_no_overwrite, !res_valid || slot_free,
              "response overwrites a pending transfer")
  `BSE_ASSERT_NEXT(a_held_on_stall, out_valid_q && !out_ready_i,
                   out_valid_q && $stable(out_rsp_q), "pending response dropped or changed")

endmodule

`default_nettype wire

// ----- design/bse_ram.sv -----
`default_nettype none

module bse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/bse_ctrl.sv -----
`default_nettype none

`include "bounded_stack_engine_assert.svh"

module bse_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire bse_pkg::bse_req_t                in_req_i,
  input  wire logic                             slot_free_i,
  output logic                                  res_valid_o,
  output bse_pkg::bse_rsp_t                     res_o,
  output logic                                  mem_we_o,
  output logic [$clog2(DEPTH)-1:0]              mem_waddr_o,
  output logic [bse_pkg::DataW-1:0]             mem_wdata_o,
  output logic [$clog2(DEPTH)-1:0]              mem_raddr_o,
  input  wire logic [bse_pkg::DataW-1:0]        mem_rdata_i
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CntW = bse_pkg::CountW;

  bse_pkg::bse_state_e state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] kept_q, kept_d;
  logic          rm_vld_q, rm_vld_d;
  logic signed [bse_pkg::DataW-1:0] value_q, value_d;

  logic          accept;
  logic          empty;
  logic          full;
  logic [CW-1:0] top_idx;
  logic          walk_done;
  bse_pkg::bse_status_e res_status;
  logic signed [bse_pkg::DataW-1:0] res_data;

  assign in_ready_o = (state_q == bse_pkg::ST_IDLE) && slot_free_i;
  assign accept     = in_valid_i && in_ready_o;
  assign empty      = (fill_q == '0);
  assign full       = (fill_q == CW'(DEPTH));
  assign top_idx    = fill_q - CW'(1);
  assign walk_done  = (rd_ptr_q == fill_q) && !rm_vld_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bse_pkg::ST_IDLE: begin
        if (accept && !empty) begin
          unique case (in_req_i.func) inside
            bse_pkg::FUNC_POP, bse_pkg::FUNC_PEEK: state_d = bse_pkg::ST_TOP;
            bse_pkg::FUNC_REMOVE:                  state_d = bse_pkg::ST_REMOVE;
            default:                               state_d = bse_pkg::ST_IDLE;
          endcase
        end
      end
      bse_pkg::ST_TOP: state_d = bse_pkg::ST_IDLE;
      bse_pkg::ST_REMOVE: begin
        if (walk_done) begin
          state_d = bse_pkg::ST_IDLE;
        end
      end
      default: state_d = bse_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fill_d      = fill_q;
    rd_ptr_d    = rd_ptr_q;
    kept_d      = kept_q;
    rm_vld_d    = 1'b0;
    value_d     = value_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = fill_q[AW-1:0];
    mem_wdata_o = in_req_i.value;
    mem_raddr_o = rd_ptr_q[AW-1:0];
    res_valid_o = 1'b0;
    res_status  = bse_pkg::STAT_REFUSED;
    res_data    = '0;
    unique case (state_q)
      bse_pkg::ST_IDLE: begin
        if (accept) begin
          value_d  = in_req_i.value;
          rd_ptr_d = '0;
          kept_d   = '0;
          unique case (in_req_i.func)
            bse_pkg::FUNC_PUSH: begin
              res_valid_o = 1'b1;
              if (!full) begin
                mem_we_o   = 1'b1;
                fill_d     = fill_q + CW'(1);
                res_status = bse_pkg::STAT_DONE;
              end
            end
            bse_pkg::FUNC_POP: begin
              mem_raddr_o = top_idx[AW-1:0];
              if (empty) begin
                res_valid_o = 1'b1;
              end else begin
                fill_d = top_idx;
              end
            end
            bse_pkg::FUNC_PEEK: begin
              mem_raddr_o = top_idx[AW-1:0];
              res_valid_o = empty;
            end
            bse_pkg::FUNC_CLEAR: begin
              res_valid_o = 1'b1;
              if (!empty) begin
                fill_d     = '0;
                res_status = bse_pkg::STAT_DONE;
              end
            end
            bse_pkg::FUNC_REMOVE: res_valid_o = empty;
            default:              res_valid_o = 1'b1;
          endcase
        end
      end
      bse_pkg::ST_TOP: begin
        res_valid_o = 1'b1;
        res_status  = bse_pkg::STAT_DONE;
        res_data    = mem_rdata_i;
      end
      bse_pkg::ST_REMOVE: begin
        if (rd_ptr_q != fill_q) begin
          rd_ptr_d = rd_ptr_q + CW'(1);
          rm_vld_d = 1'b1;
        end
        // keep survivors, packing them down toward the bottom
        if (rm_vld_q && (mem_rdata_i != value_q)) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = kept_q[AW-1:0];
          mem_wdata_o = mem_rdata_i;
          kept_d      = kept_q + CW'(1);
        end
        if (walk_done) begin
          fill_d      = kept_q;
          res_valid_o = 1'b1;
          res_status  = (kept_q == '0) ? bse_pkg::STAT_EMPTIED : bse_pkg::STAT_DONE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.status   = res_status;
    res_o.data     = res_data;
    res_o.count    = CntW'(fill_d);
    res_o.is_empty = (fill_d == '0);
    res_o.is_full  = (fill_d == CW'(DEPTH));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bse_pkg::ST_IDLE;
      fill_q   <= '0;
      rd_ptr_q <= '0;
      kept_q   <= '0;
      rm_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      rd_ptr_q <= rd_ptr_d;
      kept_q   <= kept_d;
      rm_vld_q <= rm_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  `BSE_ASSERT(a_fill_bound, fill_q <= CW'(DEPTH), "fill count beyond depth")
  `BSE_ASSERT(a_compact_behind,
              (state_q != bse_pkg::ST_REMOVE) || (kept_q <= rd_ptr_q),
              "compaction write ahead of read pointer")
  `BSE_ASSERT_NEXT(a_remove_shrinks, state_q == bse_pkg::ST_REMOVE,
                   fill_q <= $past(fill_q), "removal grew the stack")
  `BSE_ASSERT_NEXT(a_pop_decrements,
                   accept && (in_req_i.func == bse_pkg::FUNC_POP) && !empty,
                   fill_q == $past(top_idx), "pop did not drop one entry")

endmodule

`default_nettype wire
